### src/dits_pkg.sv
// Shared widths, codes and controller/datapath interface types for the device ID table search.
`default_nettype none

package dits_pkg;

    // Field widths
    localparam int CFG_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int KEY_W   = 16;
    localparam int NARROW_W = 8;
    localparam int COUNT_W = 9;
    localparam int ENTRY_W = 2 * KEY_W + 3 * NARROW_W;

    // Table defaults and the key value that matches anything
    localparam int unsigned DEF_TABLE_DEPTH = 256;
    localparam logic [KEY_W-1:0] WILDCARD_KEY = 16'hFFFF;

    // Operation codes of an input word
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write_entry;
        logic load_query;
        logic scan_step;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic bound_small;
    } ctl_sts_t;

endpackage

`default_nettype wire

### src/device_id_table_search_unit.sv
// Top level of the device ID table search: ties the controller to the datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------------
//  in      | in_valid / in_ready     | operation, entry_slot, five keys, wanted_rank
//  out     | out_valid / out_ready   | match_count, found_slot
//  cfg     | cfg_write_en            | cfg_write_data (entries_in_use)
//
// A write word is stored at its accept. A query runs from the accept through scan states
// that read one memory entry each (slots 1 to B - 1, B being entries_in_use clamped to the
// table depth; none when B < 2), a drain state to compare the last read and a finish state to post the result.
// Reset clears the controller, counters and the bound register; table contents
// stay undefined until written. A stalled result waits in the output register
// while the block goes back to taking words; the next query result waits for it.
`default_nettype none

module device_id_table_search_unit
    import dits_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [CFG_W-1:0]    cfg_write_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                operation,
    input  wire logic [SLOT_W-1:0]   entry_slot,
    input  wire logic [KEY_W-1:0]    vendor_value,
    input  wire logic [KEY_W-1:0]    product_value,
    input  wire logic [KEY_W-1:0]    class_value,
    input  wire logic [KEY_W-1:0]    subclass_value,
    input  wire logic [KEY_W-1:0]    interface_value,
    input  wire logic [SLOT_W-1:0]   wanted_rank,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COUNT_W-1:0]       match_count,
    output logic [SLOT_W-1:0]        found_slot
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    dits_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dits_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .cmd             (cmd),
        .sts             (sts),
        .entry_slot      (entry_slot),
        .vendor_value    (vendor_value),
        .product_value   (product_value),
        .class_value     (class_value),
        .subclass_value  (subclass_value),
        .interface_value (interface_value),
        .wanted_rank     (wanted_rank),
        .match_count     (match_count),
        .found_slot      (found_slot)
    );

endmodule

`default_nettype wire

### src/dits_ctrl.sv
// Controller state machine for the device ID table search: handshakes and scan sequencing.
`default_nettype none

module dits_ctrl
    import dits_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     operation,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    // Take a new word only between queries
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Drive datapath commands
    always_comb
    begin
        cmd.write_entry = accept && (operation == OP_WRITE);
        cmd.load_query  = accept && (operation == OP_QUERY);
        cmd.scan_step   = (state_reg == S_SCAN);
        cmd.load_out    = (state_reg == S_FINISH) && out_free;
    end

    // Advance the scan sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load_query)
                begin
                    state_next = sts.bound_small ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### src/dits_datapath.sv
// Datapath for the device ID table search: entry memory, key compare, count and rank tracking.
`default_nettype none

module dits_datapath
    import dits_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [CFG_W-1:0]    cfg_write_data,
    input  wire ctl_cmd_t            cmd,
    output ctl_sts_t                 sts,
    input  wire logic [SLOT_W-1:0]   entry_slot,
    input  wire logic [KEY_W-1:0]    vendor_value,
    input  wire logic [KEY_W-1:0]    product_value,
    input  wire logic [KEY_W-1:0]    class_value,
    input  wire logic [KEY_W-1:0]    subclass_value,
    input  wire logic [KEY_W-1:0]    interface_value,
    input  wire logic [SLOT_W-1:0]   wanted_rank,
    output logic [COUNT_W-1:0]       match_count,
    output logic [SLOT_W-1:0]        found_slot
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
    localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > CFG_MAX) ? CFG_MAX : TABLE_DEPTH;

    logic [ENTRY_W-1:0]  entry_mem [TABLE_DEPTH];

    logic [CFG_W-1:0]    entries_reg;
    logic [CFG_W-1:0]    eff_bound;
    logic [CFG_W-1:0]    bound_reg;
    logic [CFG_W-1:0]    scan_idx_reg;
    logic [CFG_W-1:0]    scan_idx_next;
    logic [KEY_W-1:0]    vendor_key_reg;
    logic [KEY_W-1:0]    product_key_reg;
    logic [KEY_W-1:0]    class_key_reg;
    logic [KEY_W-1:0]    subclass_key_reg;
    logic [KEY_W-1:0]    interface_key_reg;
    logic [SLOT_W-1:0]   rank_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [CFG_W-1:0]    rd_idx_reg;
    logic                hit_valid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SLOT_W-1:0]   found_reg;
    logic [SLOT_W-1:0]   found_next;
    logic                found_hit_reg;
    logic                found_hit_next;
    logic [COUNT_W-1:0]  match_count_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic                slot_ok;
    logic                entry_hit;

    // Hold the scan bound register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            entries_reg <= cfg_write_data;
        end
    end

    // Clamp the bound to the table depth
    assign eff_bound = (entries_reg > CFG_W'(DEPTH_CAP)) ? CFG_W'(DEPTH_CAP) : entries_reg;

    assign sts.bound_small = (eff_bound <= CFG_W'(1));
    assign sts.scan_last   = (scan_idx_reg == bound_reg - CFG_W'(1));

    // Store an entry; drop writes beyond the table
    assign slot_ok = (32'(entry_slot) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && slot_ok)
        begin
            entry_mem[ADDR_W'(entry_slot)] <= {vendor_value, product_value,
                                               class_value[NARROW_W-1:0],
                                               subclass_value[NARROW_W-1:0],
                                               interface_value[NARROW_W-1:0]};
        end
    end

    // Read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_mem[ADDR_W'(scan_idx_reg)];
        rd_idx_reg  <= scan_idx_reg;
    end

    // Latch query keys and bound
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            vendor_key_reg    <= vendor_value;
            product_key_reg   <= product_value;
            class_key_reg     <= class_value;
            subclass_key_reg  <= subclass_value;
            interface_key_reg <= interface_value;
            rank_reg          <= wanted_rank;
            bound_reg         <= eff_bound;
        end
    end

    // Advance the scan index
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.load_query)
        begin
            scan_idx_next = CFG_W'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + CFG_W'(1);
        end
    end

    // Compare each field against its key or the wildcard
    always_comb
    begin
        entry_hit =
            ((vendor_key_reg == WILDCARD_KEY) ||
             (vendor_key_reg == rd_data_reg[ENTRY_W-1 -: KEY_W])) &&
            ((product_key_reg == WILDCARD_KEY) ||
             (product_key_reg == rd_data_reg[ENTRY_W-KEY_W-1 -: KEY_W])) &&
            ((class_key_reg == WILDCARD_KEY) ||
             (class_key_reg == KEY_W'(rd_data_reg[3*NARROW_W-1 -: NARROW_W]))) &&
            ((subclass_key_reg == WILDCARD_KEY) ||
             (subclass_key_reg == KEY_W'(rd_data_reg[2*NARROW_W-1 -: NARROW_W]))) &&
            ((interface_key_reg == WILDCARD_KEY) ||
             (interface_key_reg == KEY_W'(rd_data_reg[NARROW_W-1:0])));
    end

    // Count matches and catch the wanted rank
    always_comb
    begin
        count_next     = count_reg;
        found_next     = found_reg;
        found_hit_next = found_hit_reg;
        if (cmd.load_query)
        begin
            count_next     = '0;
            found_next     = '0;
            found_hit_next = 1'b0;
        end
        else if (hit_valid_reg && entry_hit)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (!found_hit_reg && (count_reg == COUNT_W'(rank_reg)))
            begin
                found_next     = SLOT_W'(rd_idx_reg);
                found_hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            hit_valid_reg <= 1'b0;
            count_reg     <= '0;
            found_reg     <= '0;
            found_hit_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            hit_valid_reg <= cmd.scan_step;
            count_reg     <= count_next;
            found_reg     <= found_next;
            found_hit_reg <= found_hit_next;
        end
    end

    // Hold the result word for the sink
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            match_count_reg <= count_reg;
            found_slot_reg  <= found_reg;
        end
    end

    assign match_count = match_count_reg;
    assign found_slot  = found_slot_reg;

    a_scan_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (scan_idx_reg != '0) && (scan_idx_reg < bound_reg))
        else $error("scan index outside the table bound");

    a_count_below_idx: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid_reg |-> (count_reg < rd_idx_reg))
        else $error("match count ahead of scanned entries");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_valid_reg && entry_hit && !found_hit_reg && (count_reg == COUNT_W'(rank_reg)))
        |=> found_hit_reg && (found_reg == SLOT_W'($past(rd_idx_reg))))
        else $error("wanted rank match not captured");

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for device_id_table_search_unit: table writes and wildcard queries.
`default_nettype none

module tb;
    import dits_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int N_PHASES = 12;

    // One input word, one stored entry, one reply
    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    vendor;
        logic [KEY_W-1:0]    product;
        logic [KEY_W-1:0]    cls;
        logic [KEY_W-1:0]    sub;
        logic [KEY_W-1:0]    pif;
        logic [SLOT_W-1:0]   rank;
    } dev_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]    vendor;
        logic [KEY_W-1:0]    product;
        logic [NARROW_W-1:0] cls;
        logic [NARROW_W-1:0] sub;
        logic [NARROW_W-1:0] pif;
    } dev_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SLOT_W-1:0]   slot;
    } dev_reply_t;

    // Mirror of the table and bound; predicts each query reply in arrival order
    class id_table_scoreboard;
        dev_entry_t slots_mem [DEPTH];
        bit         written [DEPTH];
        int         bound;
        dev_reply_t pending_replies [$];
        int         errors;

        function bit key_hits(logic [KEY_W-1:0] key, logic [KEY_W-1:0] stored);
            return key == WILDCARD_KEY || key == stored;
        endfunction

        function void take_word(dev_word_t w);
            int         top;
            int         hits;
            dev_reply_t r;
            dev_entry_t e;
            bit         have;
            if (w.op == OP_WRITE)
            begin
                e.vendor  = w.vendor;
                e.product = w.product;
                e.cls     = w.cls[NARROW_W-1:0];
                e.sub     = w.sub[NARROW_W-1:0];
                e.pif     = w.pif[NARROW_W-1:0];
                slots_mem[w.slot] = e;
                written[w.slot] = 1'b1;
                return;
            end
            top = bound > DEPTH ? DEPTH : bound;
            hits = 0;
            have = 1'b0;
            r.slot = '0;
            // Scan from entry 1; entry 0 never takes part
            for (int k = 1; k < top; k++)
            begin
                e = slots_mem[k];
                if (key_hits(w.vendor, e.vendor) && key_hits(w.product, e.product) &&
                    key_hits(w.cls, {8'h00, e.cls}) && key_hits(w.sub, {8'h00, e.sub}) &&
                    key_hits(w.pif, {8'h00, e.pif}))
                begin
                    if (!have && hits == w.rank)
                    begin
                        r.slot = k[SLOT_W-1:0];
                        have = 1'b1;
                    end
                    hits++;
                end
            end
            r.count = hits[COUNT_W-1:0];
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [COUNT_W-1:0] count, logic [SLOT_W-1:0] slot);
            dev_reply_t exp_r;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with nothing expected: match_count %0d found_slot %0d",
                         $time, count, slot);
                errors++;
                return;
            end
            exp_r = pending_replies.pop_front();
            if (count !== exp_r.count)
            begin
                $display("%0t: match_count expected %0d, got %0d", $time, exp_r.count, count);
                errors++;
            end
            if (slot !== exp_r.slot)
            begin
                $display("%0t: found_slot expected %0d, got %0d", $time, exp_r.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [CFG_W-1:0]    cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                operation = OP_WRITE;
    logic [SLOT_W-1:0]   entry_slot = '0;
    logic [KEY_W-1:0]    vendor_value = '0;
    logic [KEY_W-1:0]    product_value = '0;
    logic [KEY_W-1:0]    class_value = '0;
    logic [KEY_W-1:0]    subclass_value = '0;
    logic [KEY_W-1:0]    interface_value = '0;
    logic [SLOT_W-1:0]   wanted_rank = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [COUNT_W-1:0]  match_count;
    logic [SLOT_W-1:0]   found_slot;

    id_table_scoreboard book = new();
    int send_idle_pct = 14;
    int recv_idle_pct = 62;
    int cycles = 0;
    int bounds [N_PHASES] = '{2, 9, 33, 0, 70, 1, 128, 200, 256, 511, 300, 257};

    device_id_table_search_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .entry_slot      (entry_slot),
        .vendor_value    (vendor_value),
        .product_value   (product_value),
        .class_value     (class_value),
        .subclass_value  (subclass_value),
        .interface_value (interface_value),
        .wanted_rank     (wanted_rank),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .match_count     (match_count),
        .found_slot      (found_slot)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every reply taken
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            book.check_reply(match_count, found_slot);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic dev_word_t mk_word(logic op, logic [SLOT_W-1:0] slot,
                                          logic [KEY_W-1:0] v, logic [KEY_W-1:0] p,
                                          logic [KEY_W-1:0] c, logic [KEY_W-1:0] s,
                                          logic [KEY_W-1:0] i, logic [SLOT_W-1:0] rank);
        dev_word_t w;
        w.op = op;
        w.slot = slot;
        w.vendor = v;
        w.product = p;
        w.cls = c;
        w.sub = s;
        w.pif = i;
        w.rank = rank;
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] pick_wide();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h1234;
            3: return 16'h8086;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Low byte from a short list or at random; upper byte is dropped by the table
    function automatic logic [KEY_W-1:0] pick_narrow();
        logic [7:0] lo;
        logic [7:0] hi;
        case ($urandom_range(0, 4))
            0: lo = 8'h00;
            1: lo = 8'hFF;
            2: lo = 8'h01;
            3: lo = 8'h80;
            default: lo = 8'($urandom_range(0, 255));
        endcase
        hi = ($urandom_range(0, 99) < 70) ? 8'h00 : 8'($urandom_range(0, 255));
        return {hi, lo};
    endfunction

    function automatic logic [KEY_W-1:0] query_key(logic [KEY_W-1:0] stored,
                                                   logic [KEY_W-1:0] pool);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return WILDCARD_KEY;
        if (r < 70)
            return stored;
        if (r < 85)
            return pool;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Fill any hole in the scan range first, else mix writes and queries
    function automatic dev_word_t random_word();
        dev_word_t  w;
        dev_entry_t e;
        int         top;
        int         hole;
        int         r;
        top = book.bound > DEPTH ? DEPTH : book.bound;
        hole = 0;
        for (int k = top - 1; k >= 1; k--)
            if (!book.written[k])
                hole = k;
        r = $urandom_range(0, 99);
        w.rank = (r < 50) ? 8'($urandom_range(0, 3)) :
                 (r < 80) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
        if (hole != 0 || $urandom_range(0, 99) < 35)
        begin
            w.op = OP_WRITE;
            if (hole != 0)
                w.slot = 8'(hole);
            else if (top > 1 && $urandom_range(0, 1) == 1)
                w.slot = 8'($urandom_range(0, top - 1));
            else
                w.slot = 8'($urandom_range(0, DEPTH - 1));
            w.vendor = pick_wide();
            w.product = pick_wide();
            w.cls = pick_narrow();
            w.sub = pick_narrow();
            w.pif = pick_narrow();
        end
        else
        begin
            w.op = OP_QUERY;
            w.slot = 8'($urandom_range(0, 255));
            e = book.slots_mem[(top >= 2) ? 8'($urandom_range(1, top - 1)) :
                                            8'($urandom_range(0, DEPTH - 1))];
            w.vendor = query_key(e.vendor, pick_wide());
            w.product = query_key(e.product, pick_wide());
            w.cls = query_key({8'h00, e.cls}, pick_narrow());
            w.sub = query_key({8'h00, e.sub}, pick_narrow());
            w.pif = query_key({8'h00, e.pif}, pick_narrow());
        end
        return w;
    endfunction

    // Present one word, hold it until taken, then log it
    task automatic send_word(dev_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= w.op;
        entry_slot      <= w.slot;
        vendor_value    <= w.vendor;
        product_value   <= w.product;
        class_value     <= w.cls;
        subclass_value  <= w.sub;
        interface_value <= w.pif;
        wanted_rank     <= w.rank;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        book.take_word(w);
    endtask

    // Drain all replies, let a trailing write settle, then load the bound
    task automatic set_bound(int b);
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= b[CFG_W-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
        book.bound = b;
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Bound zero and one: nothing scanned
        send_word(mk_word(OP_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'hFF));
        set_bound(1);
        send_word(mk_word(OP_QUERY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'h00));

        // Small table with duplicates; entry zero holds a match that must be skipped
        send_word(mk_word(OP_WRITE, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'hFF));
        send_word(mk_word(OP_WRITE, 8'd1, 16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF,
                          16'h0001, 8'h00));
        send_word(mk_word(OP_WRITE, 8'd2, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h0000,
                          16'hFFFF, 8'h00));
        send_word(mk_word(OP_WRITE, 8'd3, 16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF,
                          16'h0001, 8'h00));
        send_word(mk_word(OP_WRITE, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'hFF));
        set_bound(4);

        // Rank first, last, past the end; narrow keys above a byte; exact hit
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd0));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd2));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd3));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd255));
        send_word(mk_word(OP_QUERY, 8'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd1));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'h0100, 16'hFFFF,
                          16'hFFFF, 8'd0));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF,
                          16'hFFFF, 8'd0));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd0));
        send_word(mk_word(OP_QUERY, 8'd0, 16'hFFFE, 16'h0000, 16'h00FF, 16'h0000,
                          16'h00FF, 8'd0));
        send_word(mk_word(OP_QUERY, 8'd0, 16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 8'd0));

        // Random phases: one bound each, idling regime changes every four phases
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 14;
            end
            else if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_bound(bounds[ph]);
            repeat (117) send_word(random_word());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (book.errors == 0 && book.pending_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
